/* rtl/mssm_pkg.sv */
// Shared constants, types and RAM write port struct for the multi-stack unit.
// Depends on nothing; imported by mssm_slot_ram, the top level and the testbench.
`default_nettype none

package mssm_pkg;

  // Shared slot memory size and number of stacks
  localparam int MEM_DEPTH   = 64;
  localparam int STACK_COUNT = 5;

  // Field widths fixed by the item format
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 3;
  localparam int COUNT_W = 7;

  // Derived widths
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int PTR_W  = $clog2(MEM_DEPTH + 1);
  localparam int SEL_W  = $clog2(STACK_COUNT + 1);

  // Operation codes carried by an item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [KEY_W-1:0]  key_t;

  // Write request into the slot RAM
  typedef struct packed {
    logic  en;
    addr_t addr;
    key_t  data;
  } ram_wr_t;

endpackage

`default_nettype wire

/* rtl/mssm_slot_ram.sv */
// Slot RAM: one write port and one read port with registered read data.
// Depends on mssm_pkg for the address/data types and the write struct.
`default_nettype none

module mssm_slot_ram
  import mssm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire ram_wr_t wr_i,
  input  wire addr_t   rd_addr_i,
  output key_t         rd_data_o
);

  key_t mem [MEM_DEPTH];

  // Write one slot, read one slot each cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* rtl/multi_stack_shared_memory_unit.sv */
// Several stacks sharing one slot RAM; full stacks borrow room by shifting neighbors.
// A push into a full stack first walks the higher stacks, then the lower ones, shifting each
// neighbor that has room. One item at a time; busy is low while done_o shows, and results
// cannot be stalled. Reset: asynchronous, stacks empty in near-equal slices.
`default_nettype none

module multi_stack_shared_memory_unit
  import mssm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [INDEX_W-1:0] stack_index_i,
  input  wire logic signed [KEY_W-1:0] push_key_i,
  output logic                    done_o,
  output logic                    success_o,
  output logic signed [KEY_W-1:0] popped_key_o,
  output logic [COUNT_W-1:0]      stack_count_o,
  output logic [COUNT_W-1:0]      total_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHECK,
    S_DN_CHECK,
    S_MOVE,
    S_POP_WAIT,
    S_PUSH,
    S_FINISH
  } state_e;

  state_e             state_q;
  logic               op_q;
  logic [INDEX_W-1:0] idx_q;
  key_t               key_q;
  sel_t               x_q;
  logic               up_q;
  ptr_t               cnt_q;
  addr_t              cur_q;
  logic               pend_q;
  addr_t              paddr_q;
  logic               ok_q;
  key_t               popped_q;
  ptr_t               total_q;
  // Offset pointers: stack k holds slots bot_q[k] .. top_q[k]-1; last entry is the end mark
  ptr_t               bot_q [STACK_COUNT+1];
  ptr_t               top_q [STACK_COUNT+1];

  ram_wr_t ram_wr;
  addr_t   ram_rd_addr;
  key_t    ram_rd_data;

  logic k_valid;
  sel_t k;
  sel_t k_nxt;
  sel_t x_nxt;
  sel_t x_prv;
  logic k_full;
  logic k_empty;
  logic x_full;
  logic xm_full;
  ptr_t x_len;
  ptr_t k_len;

  mssm_slot_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Decode addressed stack and neighbor conditions
  always_comb begin
    k_valid = (32'(idx_q) < STACK_COUNT);
    k       = SEL_W'(idx_q);
    k_nxt   = k + sel_t'(1);
    x_nxt   = x_q + sel_t'(1);
    x_prv   = x_q - sel_t'(1);
    k_full  = (top_q[k] == bot_q[k_nxt]);
    k_empty = (top_q[k] == bot_q[k]);
    x_full  = (top_q[x_q] == bot_q[x_nxt]);
    xm_full = (top_q[x_prv] == bot_q[x_q]);
    x_len   = top_q[x_q] - bot_q[x_q];
    k_len   = top_q[k] - bot_q[k];
  end

  // Drive the RAM ports: move writes land in the cycle after their reads
  always_comb begin
    ram_wr      = '0;
    ram_rd_addr = cur_q;
    if (state_q == S_DECIDE) begin
      ram_rd_addr = ADDR_W'(top_q[k] - ptr_t'(1));
    end
    if (state_q == S_MOVE && pend_q) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = up_q ? (paddr_q + addr_t'(1)) : (paddr_q - addr_t'(1));
      ram_wr.data = ram_rd_data;
    end else if (state_q == S_PUSH && !k_full) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = ADDR_W'(top_q[k]);
      ram_wr.data = key_q;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Sequencer, pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_PUSH;
      idx_q         <= '0;
      key_q         <= '0;
      x_q           <= '0;
      up_q          <= 1'b0;
      cnt_q         <= '0;
      cur_q         <= '0;
      pend_q        <= 1'b0;
      paddr_q       <= '0;
      ok_q          <= 1'b0;
      popped_q      <= '0;
      total_q       <= '0;
      done_o        <= 1'b0;
      success_o     <= 1'b0;
      popped_key_o  <= '0;
      stack_count_o <= '0;
      total_count_o <= '0;
      for (int i = 0; i <= STACK_COUNT; i++) begin
        bot_q[i] <= PTR_W'(i * MEM_DEPTH / STACK_COUNT);
        top_q[i] <= PTR_W'(i * MEM_DEPTH / STACK_COUNT);
      end
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          // Take a new item
          if (start) begin
            op_q     <= op_i;
            idx_q    <= stack_index_i;
            key_q    <= push_key_i;
            ok_q     <= 1'b0;
            popped_q <= '0;
            state_q  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!k_valid) begin
            state_q <= S_FINISH;
          end else if (op_q == OP_POP) begin
            state_q <= k_empty ? S_FINISH : S_POP_WAIT;
          end else if (!k_full) begin
            state_q <= S_PUSH;
          end else begin
            x_q     <= sel_t'(STACK_COUNT - 1);
            state_q <= S_UP_CHECK;
          end
        end
        S_UP_CHECK: begin
          // Walk higher stacks from the last one down, shift each up if it has room
          pend_q <= 1'b0;
          if (x_q > k) begin
            if (!x_full) begin
              if (x_len != '0) begin
                cur_q   <= ADDR_W'(top_q[x_q] - ptr_t'(1));
                cnt_q   <= x_len;
                up_q    <= 1'b1;
                state_q <= S_MOVE;
              end else begin
                bot_q[x_q] <= bot_q[x_q] + ptr_t'(1);
                top_q[x_q] <= top_q[x_q] + ptr_t'(1);
                x_q        <= x_prv;
              end
            end else begin
              x_q <= x_prv;
            end
          end else if (k_full) begin
            x_q     <= sel_t'(1);
            state_q <= S_DN_CHECK;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_DN_CHECK: begin
          // Walk lower stacks from stack 1 up, shift each down if the one below has room
          pend_q <= 1'b0;
          if (x_q <= k) begin
            if (!xm_full) begin
              if (x_len != '0) begin
                cur_q   <= ADDR_W'(bot_q[x_q]);
                cnt_q   <= x_len;
                up_q    <= 1'b0;
                state_q <= S_MOVE;
              end else begin
                bot_q[x_q] <= bot_q[x_q] - ptr_t'(1);
                top_q[x_q] <= top_q[x_q] - ptr_t'(1);
                x_q        <= x_nxt;
              end
            end else begin
              x_q <= x_nxt;
            end
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_MOVE: begin
          // Stream entries one slot over; the last write lands on the final cycle
          pend_q  <= (cnt_q != '0);
          paddr_q <= cur_q;
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - ptr_t'(1);
            cur_q <= up_q ? (cur_q - addr_t'(1)) : (cur_q + addr_t'(1));
          end else if (up_q) begin
            bot_q[x_q] <= bot_q[x_q] + ptr_t'(1);
            top_q[x_q] <= top_q[x_q] + ptr_t'(1);
            x_q        <= x_prv;
            state_q    <= S_UP_CHECK;
          end else begin
            bot_q[x_q] <= bot_q[x_q] - ptr_t'(1);
            top_q[x_q] <= top_q[x_q] - ptr_t'(1);
            x_q        <= x_nxt;
            state_q    <= S_DN_CHECK;
          end
        end
        S_POP_WAIT: begin
          popped_q <= ram_rd_data;
          top_q[k] <= top_q[k] - ptr_t'(1);
          total_q  <= total_q - ptr_t'(1);
          ok_q     <= 1'b1;
          state_q  <= S_FINISH;
        end
        S_PUSH: begin
          // Key is written by the RAM port this cycle when there is room
          if (!k_full) begin
            top_q[k] <= top_q[k] + ptr_t'(1);
            total_q  <= total_q + ptr_t'(1);
            ok_q     <= 1'b1;
          end
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          done_o        <= 1'b1;
          success_o     <= ok_q;
          popped_key_o  <= popped_q;
          stack_count_o <= k_valid ? COUNT_W'(k_len) : '0;
          total_count_o <= COUNT_W'(total_q);
          state_q       <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on sequencing and bookkeeping
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted item did not start work");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MEM_DEPTH)
    else $error("total count beyond memory size");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (popped_key_o == '0))
    else $error("failed item carries a key");

endmodule

`default_nettype wire

/* bench/tb_multi_stack_shared_memory_unit.sv */
// Self-checking testbench for the multi-stack shared memory unit: push and pop items
// are driven through the start/busy handshake and every done_o result is checked.
// Depends on mssm_pkg and multi_stack_shared_memory_unit.
`timescale 1ns / 1ps

module tb_multi_stack_shared_memory_unit;
  import mssm_pkg::*;

  localparam int  HALF_PERIOD    = 6;
  localparam int  RESET_CYCLES   = 10;
  localparam int  DRAIN_CYCLES   = MEM_DEPTH + 2 * STACK_COUNT + 8;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  MAX_REPORTS    = 40;
  localparam int  MIX_ITEMS      = 440;

  typedef struct {
    logic               ok;
    key_t               popped;
    logic [COUNT_W-1:0] stack_cnt;
    logic [COUNT_W-1:0] total_cnt;
  } stack_outcome_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               op          = OP_PUSH;
  logic [INDEX_W-1:0] stack_idx   = '0;
  key_t               push_key    = '0;
  logic               busy;
  logic               done;
  logic               success;
  key_t               popped_key;
  logic [COUNT_W-1:0] stack_count;
  logic [COUNT_W-1:0] total_count;

  // Image of the shared memory and the stack pointers
  key_t img_slot   [MEM_DEPTH];
  int   img_bottom [STACK_COUNT + 1];
  int   img_top    [STACK_COUNT + 1];

  stack_outcome_t pending_outcomes[$];
  int             mismatch_count = 0;
  int             idle_pct       = 0;
  int             quiet_cycles   = 0;

  multi_stack_shared_memory_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op),
    .stack_index_i (stack_idx),
    .push_key_i    (push_key),
    .done_o        (done),
    .success_o     (success),
    .popped_key_o  (popped_key),
    .stack_count_o (stack_count),
    .total_count_o (total_count)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic logic img_full(int k);
    return img_top[k] == img_bottom[k + 1];
  endfunction

  function automatic int img_total();
    int sum;
    sum = 0;
    for (int k = 0; k < STACK_COUNT; k++) sum += img_top[k] - img_bottom[k];
    return sum;
  endfunction

  // Move stack k one slot up when it has room above it
  function automatic void img_shift_up(int k);
    if (img_full(k)) return;
    for (int i = img_top[k]; i > img_bottom[k]; i--) img_slot[i + 1] = img_slot[i];
    img_top[k]++;
    img_bottom[k]++;
  endfunction

  // Move stack k one slot down when the stack below has room
  function automatic void img_shift_down(int k);
    if (img_full(k - 1)) return;
    for (int i = img_bottom[k] + 1; i <= img_top[k]; i++) img_slot[i - 1] = img_slot[i];
    img_top[k]--;
    img_bottom[k]--;
  endfunction

  // Apply one item to the image and return the result it must produce
  function automatic stack_outcome_t compute_outcome(logic item_op, int k, key_t key);
    stack_outcome_t res;
    res.ok        = 1'b0;
    res.popped    = '0;
    res.stack_cnt = '0;
    if (k < STACK_COUNT) begin
      if (item_op == OP_PUSH) begin
        // borrow room from higher stacks first, then from lower ones
        if (img_full(k)) begin
          for (int x = STACK_COUNT - 1; x > k; x--) img_shift_up(x);
          if (img_full(k)) begin
            for (int x = 1; x <= k; x++) img_shift_down(x);
          end
        end
        if (!img_full(k)) begin
          img_top[k]++;
          img_slot[img_top[k]] = key;
          res.ok = 1'b1;
        end
      end else if (img_top[k] != img_bottom[k]) begin
        res.popped = img_slot[img_top[k]];
        img_top[k]--;
        res.ok = 1'b1;
      end
      res.stack_cnt = COUNT_W'(img_top[k] - img_bottom[k]);
    end
    res.total_cnt = COUNT_W'(img_total());
    return res;
  endfunction

  function automatic key_t random_key();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string text);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, text);
  endtask

  // Hold start high with the item until the handshake takes it
  task automatic send_item(logic item_op, logic [INDEX_W-1:0] idx, key_t key);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start     <= 1'b1;
    op        <= item_op;
    stack_idx <= idx;
    push_key  <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_outcomes.push_back(compute_outcome(item_op, int'(idx), key));
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    stack_outcome_t want;
    if (rst_ni && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (success !== want.ok || popped_key !== want.popped ||
            stack_count !== want.stack_cnt || total_count !== want.total_cnt) begin
          report_mismatch($sformatf(
            "got ok=%b key=%h cnt=%0d total=%0d, want ok=%b key=%h cnt=%0d total=%0d",
            success, popped_key, stack_count, total_count,
            want.ok, want.popped, want.stack_cnt, want.total_cnt));
        end
      end
    end
  end

  // End the run when nothing is accepted for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extreme keys, every operation, empty pops and out-of-range indexes
  task automatic test_directed();
    send_item(OP_POP,  0, 32'h1234_5678);
    send_item(OP_POP,  4, 32'h0);
    send_item(OP_PUSH, 0, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 0, 32'h8000_0000);
    send_item(OP_PUSH, 4, 32'h0000_0000);
    send_item(OP_PUSH, 4, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 2, 32'hAAAA_AAAA);
    send_item(OP_PUSH, 2, 32'h5555_5555);
    send_item(OP_PUSH, 5, 32'hDEAD_BEEF);
    send_item(OP_POP,  6, 32'h0);
    send_item(OP_PUSH, 7, 32'hFFFF_FFFF);
    send_item(OP_POP,  7, 32'h8000_0000);
    send_item(OP_POP,  0, 32'h0);
    send_item(OP_POP,  0, 32'h0);
    send_item(OP_POP,  0, 32'h0);
    send_item(OP_POP,  4, 32'hFFFF_FFFF);
    send_item(OP_POP,  4, 32'h0);
    send_item(OP_POP,  2, 32'h0);
    send_item(OP_POP,  2, 32'h0);
    send_item(OP_POP,  1, 32'h0);
    send_item(OP_PUSH, 1, 32'h0F0F_0F0F);
    send_item(OP_PUSH, 3, 32'hF0F0_F0F0);
    send_item(OP_POP,  1, 32'h0);
    send_item(OP_POP,  3, 32'h0);
  endtask

  // Fill the whole memory around one busy stack, push into the full memory, then drain it
  task automatic test_fill_and_drain();
    int hot;
    int k;
    hot = $urandom_range(STACK_COUNT - 1);
    while (img_total() < MEM_DEPTH) begin
      k = ($urandom_range(99) < 60) ? hot : $urandom_range(STACK_COUNT - 1);
      send_item(OP_PUSH, INDEX_W'(k), random_key());
    end
    repeat (6) send_item(OP_PUSH, INDEX_W'($urandom_range(7)), random_key());
    send_item(OP_POP, INDEX_W'($urandom_range(7, STACK_COUNT)), random_key());
    while (img_total() > 0) begin
      if ($urandom_range(99) < 15) begin
        send_item(OP_PUSH, INDEX_W'($urandom_range(STACK_COUNT - 1)), random_key());
      end else begin
        k = $urandom_range(STACK_COUNT - 1);
        if ($urandom_range(99) < 75) begin
          while (img_top[k] == img_bottom[k]) k = (k + 1) % STACK_COUNT;
        end
        send_item(OP_POP, INDEX_W'(k), random_key());
      end
    end
  endtask

  // Random pushes and pops in stretches that lean toward filling or draining
  task automatic test_random_mix(int n);
    int push_pct;
    int k;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: push_pct = 25;
          1: push_pct = 50;
          2: push_pct = 70;
          default: push_pct = 90;
        endcase
      end
      k = ($urandom_range(99) < 92) ? $urandom_range(STACK_COUNT - 1)
                                    : $urandom_range(7, STACK_COUNT);
      send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, INDEX_W'(k),
                random_key());
    end
  endtask

  initial begin
    int phase_pct[3];
    phase_pct = '{14, 88, 0};
    for (int k = 0; k <= STACK_COUNT; k++) begin
      img_bottom[k] = k * MEM_DEPTH / STACK_COUNT - 1;
      img_top[k]    = img_bottom[k];
    end
    foreach (img_slot[i]) img_slot[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = phase_pct[0];
    test_directed();
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      test_fill_and_drain();
      test_random_mix(MIX_ITEMS);
    end

    // Drop start, wait out the last results, then give stray strobes a chance to show
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mssm_pkg.sv
rtl/mssm_slot_ram.sv
rtl/multi_stack_shared_memory_unit.sv
bench/tb_multi_stack_shared_memory_unit.sv
